// File: rtl/magp_pkg.sv
package magp_pkg;

  localparam logic [31:0] ADD_CORR_MASK = 32'h7FFF_FFFF;

  // One input word as it enters the datapath.
  typedef struct packed {
    logic        kind;
    logic [31:0] x_public;
    logic [31:0] y_public;
    logic [31:0] x_mask_share;
    logic [31:0] y_mask_share;
    logic [31:0] fresh_mask;
    logic [31:0] product_share;
  } in_word_t;

  // One result word as it leaves the output register.
  typedef struct packed {
    logic [5:0]  party;
    logic [31:0] broadcast;
    logic [31:0] out_mask_share;
    logic [31:0] out_public;
    logic [31:0] correction;
    logic [11:0] gate_index;
    logic        last;
  } out_word_t;

  // Per-party entry of the share store.
  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] m;
    logic [31:0] p;
  } share_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic first;
    logic finish;
    logic rd;
    logic emit;
    logic last;
    logic gate_adv;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_FINISH,
    ST_EMIT
  } state_t;

  // Carry mask of a word: bit j is the XOR of bits 0 to j-1.
  function automatic logic [31:0] carry_mask(input logic [31:0] w);
    logic [31:0] v;
    v = w;
    v = v ^ (v << 1);
    v = v ^ (v << 2);
    v = v ^ (v << 4);
    v = v ^ (v << 8);
    v = v ^ (v << 16);
    return v << 1;
  endfunction

endpackage

// File: rtl/magp_in_if.sv
interface magp_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [31:0] x_public;
  logic [31:0] y_public;
  logic [31:0] x_mask_share;
  logic [31:0] y_mask_share;
  logic [31:0] fresh_mask;
  logic [31:0] product_share;

  modport source (
    output valid, kind, x_public, y_public, x_mask_share, y_mask_share,
           fresh_mask, product_share,
    input  ready
  );

  modport sink (
    input  valid, kind, x_public, y_public, x_mask_share, y_mask_share,
           fresh_mask, product_share,
    output ready
  );
endinterface

// File: rtl/magp_out_if.sv
interface magp_out_if;
  logic        valid;
  logic        ready;
  logic [5:0]  party;
  logic [31:0] broadcast;
  logic [31:0] out_mask_share;
  logic [31:0] out_public;
  logic [31:0] correction;
  logic [11:0] gate_index;
  logic        last;

  modport source (
    output valid, party, broadcast, out_mask_share, out_public, correction,
           gate_index, last,
    input  ready
  );

  modport sink (
    input  valid, party, broadcast, out_mask_share, out_public, correction,
           gate_index, last,
    output ready
  );
endinterface

// File: rtl/magp_ctrl.sv
module magp_ctrl
  import magp_pkg::*;
#(
  parameter int PARTIES = 16,
  localparam int PW = $clog2(PARTIES)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output cmd_t          cmd,
  output logic [PW-1:0] waddr,
  output logic [PW-1:0] raddr,
  output logic [PW-1:0] rd_idx
);

  localparam logic [PW-1:0] LAST_PARTY = PW'(PARTIES - 1);

  state_t        state;
  state_t        state_next;
  logic [PW-1:0] lcount;
  logic [PW-1:0] icount;
  logic          issued_all;
  logic          rd_valid;
  logic          adv_rd;
  logic          adv_out;

  assign waddr = lcount;
  assign raddr = icount;

  // Read stage moves into the output register when that register is free.
  assign adv_out = (state == ST_EMIT) && rd_valid && (!out_valid || out_ready);
  assign adv_rd  = (state == ST_EMIT) && !issued_all && (!rd_valid || adv_out);

  always_comb begin
    state_next   = state;
    in_ready     = 1'b0;
    cmd          = '0;
    cmd.rd       = adv_rd;
    cmd.emit     = adv_out;
    cmd.last     = (rd_idx == LAST_PARTY);
    case (state)
      ST_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          cmd.first = (lcount == '0);
          if (lcount == LAST_PARTY) begin
            state_next = ST_FINISH;
          end
        end
      end
      ST_FINISH: begin
        cmd.finish = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (adv_out && rd_idx == LAST_PARTY) begin
          cmd.gate_adv = 1'b1;
          state_next   = ST_LOAD;
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_LOAD;
      lcount     <= '0;
      icount     <= '0;
      issued_all <= 1'b0;
      rd_valid   <= 1'b0;
      rd_idx     <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load) begin
        lcount <= (lcount == LAST_PARTY) ? '0 : lcount + PW'(1);
      end
      if (cmd.finish) begin
        icount     <= '0;
        issued_all <= 1'b0;
        rd_valid   <= 1'b0;
      end else begin
        if (adv_rd) begin
          rd_idx <= icount;
          icount <= icount + PW'(1);
          if (icount == LAST_PARTY) begin
            issued_all <= 1'b1;
          end
        end
        if (adv_rd) begin
          rd_valid <= 1'b1;
        end else if (adv_out) begin
          rd_valid <= 1'b0;
        end
      end
      if (adv_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/magp_dp.sv
module magp_dp
  import magp_pkg::*;
#(
  parameter int PARTIES    = 16,
  parameter int GATE_SLOTS = 4096,
  localparam int PW = $clog2(PARTIES),
  localparam int GW = $clog2(GATE_SLOTS)
) (
  input  logic          clk,
  input  logic          rst,
  input  cmd_t          cmd,
  input  logic [PW-1:0] waddr,
  input  logic [PW-1:0] raddr,
  input  logic [PW-1:0] rd_idx,
  input  in_word_t      word_in,
  output out_word_t     word_out
);

  share_t        mem [PARTIES];
  share_t        rd_word;

  logic [31:0]   x_mask_sum;
  logic [31:0]   y_mask_sum;
  logic [31:0]   prod_sum;
  logic [31:0]   carry_mask_sum;
  logic [31:0]   fresh_sum;
  logic          gate_op;
  logic [31:0]   x_pub_latch;
  logic [31:0]   y_pub_latch;
  logic [GW-1:0] gate_counter;

  logic          op;
  logic [31:0]   gp;
  logic [31:0]   gq;
  logic [31:0]   corr;
  logic [31:0]   zh;
  logic [31:0]   k0;

  logic [31:0]   fin_corr;
  logic [31:0]   fin_zh;
  logic [31:0]   fin_p;
  logic [31:0]   fin_q;
  logic [31:0]   xv;
  logic [31:0]   yv;
  logic [31:0]   ch;
  logic [31:0]   lci;
  logic [31:0]   bcast;
  logic [31:0]   oms;

  // Share store: one write port for loading, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mem[waddr] <= '{x: word_in.x_mask_share, y: word_in.y_mask_share,
                      m: word_in.fresh_mask, p: word_in.product_share};
    end
    if (cmd.rd) begin
      rd_word <= mem[raddr];
    end
  end

  // Gate-level values, formed once all shares have been summed.
  always_comb begin
    xv = x_pub_latch ^ x_mask_sum;
    yv = y_pub_latch ^ y_mask_sum;
    ch = ((xv + yv) ^ xv ^ yv) ^ carry_mask_sum;
    if (gate_op) begin
      fin_p    = x_pub_latch ^ ch;
      fin_q    = y_pub_latch ^ ch;
      fin_corr = (((x_mask_sum ^ carry_mask_sum) & (y_mask_sum ^ carry_mask_sum))
                  ^ prod_sum) & ADD_CORR_MASK;
      fin_zh   = x_pub_latch ^ y_pub_latch ^ ch;
    end else begin
      fin_p    = x_pub_latch;
      fin_q    = y_pub_latch;
      fin_corr = (x_mask_sum & y_mask_sum) ^ prod_sum;
      // XOR of all broadcast shares, folded through the running sums.
      fin_zh   = (x_pub_latch & y_mask_sum) ^ (y_pub_latch & x_mask_sum) ^ prod_sum
                 ^ fresh_sum ^ (x_pub_latch & y_pub_latch) ^ fin_corr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      x_mask_sum     <= '0;
      y_mask_sum     <= '0;
      prod_sum       <= '0;
      carry_mask_sum <= '0;
      fresh_sum      <= '0;
      gate_op        <= 1'b0;
      x_pub_latch    <= '0;
      y_pub_latch    <= '0;
      gate_counter   <= '0;
    end else begin
      if (cmd.load) begin
        x_mask_sum     <= x_mask_sum ^ word_in.x_mask_share;
        y_mask_sum     <= y_mask_sum ^ word_in.y_mask_share;
        prod_sum       <= prod_sum ^ word_in.product_share;
        carry_mask_sum <= carry_mask_sum ^ carry_mask(word_in.fresh_mask);
        fresh_sum      <= fresh_sum ^ word_in.fresh_mask;
        if (cmd.first) begin
          gate_op     <= word_in.kind;
          x_pub_latch <= word_in.x_public;
          y_pub_latch <= word_in.y_public;
        end
      end else if (cmd.finish) begin
        x_mask_sum     <= '0;
        y_mask_sum     <= '0;
        prod_sum       <= '0;
        carry_mask_sum <= '0;
        fresh_sum      <= '0;
      end
      if (cmd.gate_adv) begin
        gate_counter <= (gate_counter == GW'(GATE_SLOTS - 1)) ? '0
                        : gate_counter + GW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      op   <= gate_op;
      gp   <= fin_p;
      gq   <= fin_q;
      corr <= fin_corr;
      zh   <= fin_zh;
      k0   <= (fin_p & fin_q) ^ fin_corr;
    end
  end

  // Per-party result. For AND the carry mask is forced to zero, which
  // turns the ADD formula into the AND one.
  always_comb begin
    lci   = op ? carry_mask(rd_word.m) : '0;
    bcast = (gp & (rd_word.y ^ lci)) ^ (gq & (rd_word.x ^ lci)) ^ rd_word.p ^ rd_word.m;
    if (rd_idx == '0) begin
      bcast = bcast ^ k0;
    end
    oms = op ? (rd_word.x ^ rd_word.y ^ lci) : rd_word.m;
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      word_out.party          <= 6'(rd_idx);
      word_out.broadcast      <= bcast;
      word_out.out_mask_share <= oms;
      word_out.out_public     <= zh;
      word_out.correction     <= corr;
      word_out.gate_index     <= 12'(gate_counter);
      word_out.last           <= cmd.last;
    end
  end

endmodule

// File: rtl/masked_and_add_gate_prover.sv
// Channel   Dir  Interface     Words
// items     in   magp_in_if    one per party, PARTIES per gate, party 0 first
// results   out  magp_out_if   one per party after the gate's final item
//
// A gate loads one word per cycle while items are valid, PARTIES words in all,
// forms the gate-level values in the finish state, and then produces one
// result per cycle while the sink is ready, through a registered store read
// and the output register. The share store's single read port sets the
// result rate. Synchronous rst clears the control, the running sums and
// the gate counter; the share store is not cleared. A stalled results channel
// holds the read stage and the output register, and items are not taken while
// a gate's results are being produced.
module masked_and_add_gate_prover
  import magp_pkg::*;
#(
  parameter int PARTIES    = 16,
  parameter int GATE_SLOTS = 4096
) (
  input logic       clk,
  input logic       rst,
  magp_in_if.sink   items,
  magp_out_if.source results
);

  localparam int PW = $clog2(PARTIES);

  cmd_t          cmd;
  logic [PW-1:0] waddr;
  logic [PW-1:0] raddr;
  logic [PW-1:0] rd_idx;
  in_word_t      word_in;
  out_word_t     word_out;

  // Pack the incoming word for the datapath.
  assign word_in = '{kind: items.kind, x_public: items.x_public,
                     y_public: items.y_public, x_mask_share: items.x_mask_share,
                     y_mask_share: items.y_mask_share, fresh_mask: items.fresh_mask,
                     product_share: items.product_share};

  // The controller sequences loading, the finish cycle and the result pass.
  magp_ctrl #(
    .PARTIES (PARTIES)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (items.valid),
    .in_ready  (items.ready),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .cmd       (cmd),
    .waddr     (waddr),
    .raddr     (raddr),
    .rd_idx    (rd_idx)
  );

  // The datapath holds the share store, the running sums and the output register.
  magp_dp #(
    .PARTIES    (PARTIES),
    .GATE_SLOTS (GATE_SLOTS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .waddr    (waddr),
    .raddr    (raddr),
    .rd_idx   (rd_idx),
    .word_in  (word_in),
    .word_out (word_out)
  );

  assign results.party          = word_out.party;
  assign results.broadcast      = word_out.broadcast;
  assign results.out_mask_share = word_out.out_mask_share;
  assign results.out_public     = word_out.out_public;
  assign results.correction     = word_out.correction;
  assign results.gate_index     = word_out.gate_index;
  assign results.last           = word_out.last;

endmodule

// File: bench/masked_and_add_gate_prover_tb.sv
`timescale 1ns / 100ps

module masked_and_add_gate_prover_tb;
  import magp_pkg::*;

  // The bench runs the block at its default size. Every gate is exactly
  // GATE_PARTIES words, and the results of a gate come back one per party.
  localparam int GATE_PARTIES = 16;
  localparam int N_SLOTS      = 4096;

  // The tail wait after the last expected result covers one whole gate pass.
  localparam int TAIL_CYCLES = 2 * GATE_PARTIES + 8;

  typedef enum logic {
    GATE_AND = 1'b0,
    GATE_ADD = 1'b1
  } gate_kind_t;

  // The scoreboard keeps its own copy of the prover state. Each accepted item
  // word is folded into the running sums. On the final party of a gate it
  // forms the whole set of per-party results and queues them in party order.
  class gate_scoreboard;
    logic [31:0] x_share [GATE_PARTIES];
    logic [31:0] y_share [GATE_PARTIES];
    logic [31:0] fresh   [GATE_PARTIES];
    logic [31:0] prod    [GATE_PARTIES];
    logic [31:0] x_sum, y_sum, prod_sum, carry_sum;
    logic [31:0] x_pub, y_pub;
    logic        add_gate;
    int unsigned party_cnt;
    int unsigned gate_cnt;
    out_word_t   pending_results[$];
    int unsigned errors;

    function new();
      x_sum = '0;
      y_sum = '0;
      prod_sum = '0;
      carry_sum = '0;
      x_pub = '0;
      y_pub = '0;
      add_gate = 1'b0;
      party_cnt = 0;
      gate_cnt = 0;
      errors = 0;
    endfunction

    // Bit j of the carry mask is the XOR of fresh-mask bits 0 through j-1.
    function logic [31:0] prefix_carry(input logic [31:0] w);
      logic [31:0] r;
      logic        acc;
      r = '0;
      acc = 1'b0;
      for (int j = 1; j < 32; j++) begin
        acc = acc ^ w[j-1];
        r[j] = acc;
      end
      return r;
    endfunction

    function void note_item(input in_word_t w);
      int unsigned p;
      logic [31:0] corr, zh, xv, yv, ch, ph, qh, lci, s;
      logic [31:0] bc  [GATE_PARTIES];
      logic [31:0] oms [GATE_PARTIES];
      out_word_t   e;
      p = party_cnt;
      // The gate kind and both public operands come from party 0 only.
      if (p == 0) begin
        add_gate = w.kind;
        x_pub = w.x_public;
        y_pub = w.y_public;
      end
      x_share[p] = w.x_mask_share;
      y_share[p] = w.y_mask_share;
      fresh[p] = w.fresh_mask;
      prod[p] = w.product_share;
      x_sum = x_sum ^ w.x_mask_share;
      y_sum = y_sum ^ w.y_mask_share;
      prod_sum = prod_sum ^ w.product_share;
      carry_sum = carry_sum ^ prefix_carry(w.fresh_mask);
      if (p + 1 < GATE_PARTIES) begin
        party_cnt = p + 1;
        return;
      end

      if (add_gate == GATE_AND) begin
        corr = (x_sum & y_sum) ^ prod_sum;
        zh = '0;
        for (int i = 0; i < GATE_PARTIES; i++) begin
          s = (x_pub & y_share[i]) ^ (y_pub & x_share[i]) ^ prod[i] ^ fresh[i];
          if (i == 0) begin
            s = s ^ (x_pub & y_pub) ^ corr;
          end
          bc[i] = s;
          oms[i] = fresh[i];
          zh = zh ^ s;
        end
      end else begin
        // Unmask both operands, take the true carry vector and remask it
        // with the summed carry masks.
        xv = x_pub ^ x_sum;
        yv = y_pub ^ y_sum;
        ch = (xv + yv) ^ xv ^ yv ^ carry_sum;
        ph = x_pub ^ ch;
        qh = y_pub ^ ch;
        corr = (((x_sum ^ carry_sum) & (y_sum ^ carry_sum)) ^ prod_sum) & ADD_CORR_MASK;
        for (int i = 0; i < GATE_PARTIES; i++) begin
          lci = prefix_carry(fresh[i]);
          s = (ph & (y_share[i] ^ lci)) ^ (qh & (x_share[i] ^ lci)) ^ prod[i] ^ fresh[i];
          if (i == 0) begin
            s = s ^ (ph & qh) ^ corr;
          end
          bc[i] = s;
          oms[i] = x_share[i] ^ y_share[i] ^ lci;
        end
        zh = x_pub ^ y_pub ^ ch;
      end

      for (int i = 0; i < GATE_PARTIES; i++) begin
        e.party = 6'(i);
        e.broadcast = bc[i];
        e.out_mask_share = oms[i];
        e.out_public = zh;
        e.correction = corr;
        e.gate_index = 12'(gate_cnt);
        e.last = (i == GATE_PARTIES - 1);
        pending_results.push_back(e);
      end

      x_sum = '0;
      y_sum = '0;
      prod_sum = '0;
      carry_sum = '0;
      party_cnt = 0;
      gate_cnt = (gate_cnt + 1) % N_SLOTS;
    endfunction

    function void fail(input string what);
      errors++;
      if (errors <= 10) begin
        $display("[%0t] %s", $realtime, what);
      end
    endfunction

    function void compare_field(input string name, input out_word_t e,
                                input logic [31:0] want, input logic [31:0] got);
      if (want !== got) begin
        fail($sformatf("gate %0d party %0d %s: expected %h, got %h",
                       e.gate_index, e.party, name, want, got));
      end
    endfunction

    function void check_result(input out_word_t r);
      out_word_t e;
      if (pending_results.size() == 0) begin
        fail($sformatf("result word with nothing expected: party %0d gate %0d",
                       r.party, r.gate_index));
        return;
      end
      e = pending_results.pop_front();
      compare_field("party", e, 32'(e.party), 32'(r.party));
      compare_field("broadcast", e, e.broadcast, r.broadcast);
      compare_field("out_mask_share", e, e.out_mask_share, r.out_mask_share);
      compare_field("out_public", e, e.out_public, r.out_public);
      compare_field("correction", e, e.correction, r.correction);
      compare_field("gate_index", e, 32'(e.gate_index), 32'(r.gate_index));
      compare_field("last", e, 32'(e.last), 32'(r.last));
    endfunction
  endclass

  logic clk;
  logic rst;

  magp_in_if  items_ch ();
  magp_out_if results_ch ();

  masked_and_add_gate_prover #(
    .PARTIES    (GATE_PARTIES),
    .GATE_SLOTS (N_SLOTS)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .items   (items_ch),
    .results (results_ch)
  );

  gate_scoreboard sb;

  // Percent chance per cycle that the sender holds off or the sink stalls.
  int unsigned idle_pct;
  int unsigned stall_pct;
  int unsigned gates_sent;

  always #10 clk = ~clk;

  // Hard stop for a hung handshake. The slowest legal run, with both sides
  // idling in most cycles, takes well under a tenth of this time to finish.
  initial begin
    #1_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Results side. A result word is taken at an edge where valid and the
  // ready that this process drove one step earlier are both high. Ready is
  // redrawn every cycle so stalls land on every result slot of a gate.
  initial begin
    out_word_t r;
    results_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && results_ch.valid && results_ch.ready) begin
        r.party = results_ch.party;
        r.broadcast = results_ch.broadcast;
        r.out_mask_share = results_ch.out_mask_share;
        r.out_public = results_ch.out_public;
        r.correction = results_ch.correction;
        r.gate_index = results_ch.gate_index;
        r.last = results_ch.last;
        sb.check_result(r);
      end
      results_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Mostly uniform words, with a fair share of all-zero, all-one, single-bit and
  // single-zero-bit values so the carry chain and masking edges get hit often.
  function automatic logic [31:0] biased_word();
    logic [31:0] b;
    b = 32'h1 << $urandom_range(0, 31);
    case ($urandom_range(0, 9))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return b;
      3: return ~b;
      default: return $urandom();
    endcase
  endfunction

  // Directed share values cycle through zero, all ones, the top bit and the
  // bottom bit, shifted per lane so parties see different combinations.
  function automatic logic [31:0] pattern_word(input int p, input int lane);
    case ((p + lane) % 4)
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      default: return 32'h0000_0001;
    endcase
  endfunction

  // Presents one item word and holds it until the block takes it. Valid is
  // left high on return so back-to-back words need no extra assignment.
  task automatic put_item(input in_word_t w);
    while ($urandom_range(0, 99) < idle_pct) begin
      items_ch.valid <= 1'b0;
      @(posedge clk);
    end
    items_ch.valid <= 1'b1;
    items_ch.kind <= w.kind;
    items_ch.x_public <= w.x_public;
    items_ch.y_public <= w.y_public;
    items_ch.x_mask_share <= w.x_mask_share;
    items_ch.y_mask_share <= w.y_mask_share;
    items_ch.fresh_mask <= w.fresh_mask;
    items_ch.product_share <= w.product_share;
    do @(posedge clk); while (!items_ch.ready);
    sb.note_item(w);
  endtask

  // Sends one full gate, party 0 first. Only party 0's kind and public
  // operands count; later parties carry other values to show that they are
  // ignored (always in a directed gate, a quarter of the time otherwise).
  task automatic send_gate(input gate_kind_t k, input logic [31:0] xp,
                           input logic [31:0] yp, input bit directed);
    in_word_t w;
    for (int p = 0; p < GATE_PARTIES; p++) begin
      w.kind = k;
      w.x_public = xp;
      w.y_public = yp;
      if (p != 0) begin
        if (directed) begin
          w.kind = ~k;
          w.x_public = ~xp;
          w.y_public = ~yp;
        end else if ($urandom_range(0, 3) == 0) begin
          w.kind = 1'($urandom_range(0, 1));
          w.x_public = biased_word();
          w.y_public = biased_word();
        end
      end
      if (directed) begin
        w.x_mask_share = pattern_word(p, 0);
        w.y_mask_share = pattern_word(p, 1);
        w.fresh_mask = pattern_word(p, 2);
        w.product_share = pattern_word(p, 3);
      end else begin
        w.x_mask_share = biased_word();
        w.y_mask_share = biased_word();
        w.fresh_mask = biased_word();
        w.product_share = biased_word();
      end
      put_item(w);
    end
    gates_sent++;
  endtask

  task automatic send_random_gate();
    send_gate(gate_kind_t'($urandom_range(0, 1)), biased_word(), biased_word(), 1'b0);
  endtask

  initial begin
    sb = new();
    clk = 1'b0;
    rst = 1'b1;
    idle_pct = 0;
    stall_pct = 0;
    gates_sent = 0;
    items_ch.valid = 1'b0;
    items_ch.kind = GATE_AND;
    items_ch.x_public = '0;
    items_ch.y_public = '0;
    items_ch.x_mask_share = '0;
    items_ch.y_mask_share = '0;
    items_ch.fresh_mask = '0;
    items_ch.product_share = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed gates: an AND with all-one operands, then an ADD whose true
    // operands run a carry through every bit position.
    send_gate(GATE_AND, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    send_gate(GATE_ADD, 32'hFFFF_FFFF, 32'h0000_0001, 1'b1);

    // Random gates under each flow-control mix in turn.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 62; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 62; end
        default: begin idle_pct = 23; stall_pct = 23; end
      endcase
      repeat (6) send_random_gate();
    end
    items_ch.valid <= 1'b0;

    while (sb.pending_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (TAIL_CYCLES) @(posedge clk);

    if (sb.pending_results.size() != 0) begin
      sb.fail($sformatf("%0d result words never arrived", sb.pending_results.size()));
    end
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
